// ----- rtl/stepper_command_queue_pulser_top_macros.svh -----
// Assertion helpers for the checker file.
`ifndef STEPPER_COMMAND_QUEUE_PULSER_TOP_MACROS_SVH
`define STEPPER_COMMAND_QUEUE_PULSER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SCQP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define SCQP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/scqp_pkg.sv -----
`timescale 1ns / 1ps

package scqp_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] signed_steps;
    logic        [31:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic       step_level;
    logic       direction_level;
    logic [4:0] queue_count;
    logic       enqueue_rejected;
  } out_item_t;

  typedef struct packed {
    logic        is_tick;
    logic        direction;
    logic [31:0] toggles;
    logic [31:0] delay;
  } cmd_t;

endpackage

// ----- rtl/scqp_front.sv -----
`timescale 1ns / 1ps

module scqp_front import scqp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t request,
  output logic     push_valid,
  input  logic     push_ready,
  output cmd_t     push_cmd
);

  logic        held;
  cmd_t        cmd;
  cmd_t        cmd_next;
  logic [31:0] raw;
  logic [31:0] magnitude;
  logic        neg_or_zero;
  logic        take;

  assign in_stall   = held && !push_ready;
  assign take       = in_valid && !in_stall;
  assign push_valid = held;
  assign push_cmd   = cmd;

  // sign picks direction (zero counts as negative); stored as toggles = 2 * |count|, kept to 32 bits
  always_comb begin
    raw                = request.signed_steps;
    neg_or_zero        = (raw == 32'd0) || raw[31];
    magnitude          = neg_or_zero ? (32'd0 - raw) : raw;
    cmd_next.is_tick   = (request.operation == OP_TICK);
    cmd_next.direction = neg_or_zero;
    cmd_next.toggles   = {magnitude[30:0], 1'b0};
    cmd_next.delay     = request.delay_ticks;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ----- rtl/scqp_cmd_queue.sv -----
`timescale 1ns / 1ps

module scqp_cmd_queue import scqp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t                slots [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_CNT_W-1:0] fill;
  logic                push;
  logic                pop;

  assign push_ready = (fill != CQ_CNT_W'(CQ_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- rtl/scqp_back.sv -----
`timescale 1ns / 1ps

module scqp_back import scqp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  cmd_t      pop_cmd,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t result
);

  logic [31:0]      fifo_toggles_left [QUEUE_DEPTH];
  logic [31:0]      fifo_delay        [QUEUE_DEPTH];
  logic             fifo_direction    [QUEUE_DEPTH];

  logic [PTR_W-1:0] read_pointer;
  logic [PTR_W-1:0] write_pointer;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] entry_count_next;
  logic [31:0]      head_tick_counter;
  logic [31:0]      head_tick_counter_next;
  logic             pulse_level;
  logic             pulse_level_next;
  logic             direction_pin;
  logic             direction_pin_next;

  logic [31:0]      head_toggles;
  logic [31:0]      head_delay;
  logic             exec;
  logic             full;
  logic             empty;
  logic             rejected;
  logic             do_write;
  logic             do_tick;
  logic             delay_reached;
  logic             do_toggle;
  logic             do_count;
  logic             do_pop;

  assign pop_ready = !out_valid || !out_stall;
  assign exec      = pop_valid && pop_ready;

  assign head_toggles  = fifo_toggles_left[read_pointer];
  assign head_delay    = fifo_delay[read_pointer];
  assign full          = (entry_count == CNT_W'(QUEUE_DEPTH));
  assign empty         = (entry_count == '0);
  assign delay_reached = (head_tick_counter >= head_delay);

  assign rejected  = exec && !pop_cmd.is_tick && full;
  assign do_write  = exec && !pop_cmd.is_tick && !full;
  assign do_tick   = exec && pop_cmd.is_tick && !empty;
  assign do_toggle = do_tick && (head_toggles != '0) && delay_reached;
  assign do_count  = do_tick && (head_toggles != '0) && !delay_reached;
  assign do_pop    = do_tick && (head_toggles == '0);

  always_comb begin
    pulse_level_next       = pulse_level ^ do_toggle;
    direction_pin_next     = do_toggle ? fifo_direction[read_pointer] : direction_pin;
    head_tick_counter_next = head_tick_counter;
    entry_count_next       = entry_count;
    if (do_toggle || do_pop) begin
      head_tick_counter_next = '0;
    end else if (do_count) begin
      head_tick_counter_next = head_tick_counter + 32'd1;
    end
    if (do_write) begin
      entry_count_next = entry_count + 1'b1;
    end else if (do_pop) begin
      entry_count_next = entry_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer      <= '0;
      write_pointer     <= '0;
      entry_count       <= '0;
      head_tick_counter <= '0;
      pulse_level       <= 1'b0;
      direction_pin     <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      entry_count       <= entry_count_next;
      head_tick_counter <= head_tick_counter_next;
      pulse_level       <= pulse_level_next;
      direction_pin     <= direction_pin_next;
      if (do_write) begin
        write_pointer <= (write_pointer == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : write_pointer + 1'b1;
      end
      if (do_pop) begin
        read_pointer <= (read_pointer == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : read_pointer + 1'b1;
      end
      if (exec) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      fifo_toggles_left[write_pointer] <= pop_cmd.toggles;
      fifo_delay[write_pointer]        <= pop_cmd.delay;
      fifo_direction[write_pointer]    <= pop_cmd.direction;
    end else if (do_toggle) begin
      fifo_toggles_left[read_pointer] <= head_toggles - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      result.step_level       <= pulse_level_next;
      result.direction_level  <= direction_pin_next;
      result.queue_count      <= 5'(entry_count_next);
      result.enqueue_rejected <= rejected;
    end
  end

endmodule

// ----- rtl/stepper_command_queue_pulser_top.sv -----
`timescale 1ns / 1ps
// Channel  Signals                         Payload
// in       in_valid / in_stall / request   in_item_t  (enqueue or tick)
// out      out_valid / out_stall / result  out_item_t (pin levels, count, reject)
//
// Sustains one request per cycle while out is not stalled; each result is registered.
// Path: front classify register, two-entry command queue, executor with output register.
// Each tick touches only the head entry: one 32-bit compare and decrement per cycle.
// rst is synchronous; the command store needs no clearing, it is ready right after reset.
// A stall on out backs up the queue, then the front register, then in_stall.

module stepper_command_queue_pulser_top import scqp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  request,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t result
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  scqp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .request    (request),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  scqp_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  scqp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

endmodule

// ----- rtl/scqp_checker.sv -----
`timescale 1ns / 1ps
`include "stepper_command_queue_pulser_top_macros.svh"

module scqp_checker import scqp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  request,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t result
);

  `SCQP_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(request),
                    "stalled request changed")

  `SCQP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result),
                    "stalled result changed")

  `SCQP_ASSERT_NOW(a_count_range, out_valid, result.queue_count <= 5'(QUEUE_DEPTH),
                   "queue count beyond depth")

  `SCQP_ASSERT_NOW(a_reject_full, out_valid && result.enqueue_rejected,
                   result.queue_count == 5'(QUEUE_DEPTH), "reject while not full")

endmodule

bind stepper_command_queue_pulser_top scqp_checker u_checker (.*);

// ----- bench/tb_stepper_command_queue_pulser_top.sv -----
`timescale 1ns / 1ps

module tb_stepper_command_queue_pulser_top;
  import scqp_pkg::*;

  localparam int NO_PROGRESS_LIMIT = 5000;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  request;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t result;

  stepper_command_queue_pulser_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .request  (request),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result   (result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Pin / queue predictor state
  logic [31:0] toggles_mem [QUEUE_DEPTH];
  logic [31:0] delay_mem [QUEUE_DEPTH];
  logic        dir_mem [QUEUE_DEPTH];
  logic [31:0] tick_count = '0;
  int          head = 0;
  int          tail = 0;
  int          queued = 0;
  logic        pulse_level = 1'b0;
  logic        dir_pin = 1'b0;

  out_item_t expected_pins[$];
  out_item_t oldest_pins;
  int        error_count = 0;
  int        idle_cycles = 0;
  int        send_gap_pct = 0;
  int        stall_pct = 0;

  function automatic out_item_t predict_pins(in_item_t req);
    out_item_t   pins;
    logic [31:0] raw;
    logic [31:0] mag;
    logic        neg;
    pins.enqueue_rejected = 1'b0;
    if (req.operation == OP_ENQUEUE) begin
      if (queued >= QUEUE_DEPTH) begin
        pins.enqueue_rejected = 1'b1;
      end else begin
        raw = req.signed_steps;
        neg = (raw == '0) || raw[31];
        mag = neg ? (32'd0 - raw) : raw;
        dir_mem[tail] = neg;
        delay_mem[tail] = req.delay_ticks;
        toggles_mem[tail] = mag << 1;
        tail = (tail + 1) % QUEUE_DEPTH;
        queued++;
      end
    end else if (queued != 0) begin
      if (toggles_mem[head] != '0) begin
        if (tick_count >= delay_mem[head]) begin
          dir_pin = dir_mem[head];
          pulse_level = ~pulse_level;
          tick_count = '0;
          toggles_mem[head] = toggles_mem[head] - 32'd1;
        end else begin
          tick_count = tick_count + 32'd1;
        end
      end else begin
        head = (head + 1) % QUEUE_DEPTH;
        queued--;
        tick_count = '0;
      end
    end
    pins.step_level = pulse_level;
    pins.direction_level = dir_pin;
    pins.queue_count = 5'(queued);
    return pins;
  endfunction

  function automatic in_item_t make_request(logic op, logic [31:0] cnt, logic [31:0] dly);
    in_item_t req;
    req.operation = op;
    req.signed_steps = cnt;
    req.delay_ticks = dly;
    return req;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Sender: valid stays high across back-to-back requests unless send_gap_pct inserts gaps
  task automatic send_request(in_item_t req);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    request <= req;
    do @(posedge clk); while (in_stall);
    expected_pins.push_back(predict_pins(req));
  endtask

  task automatic drain_pins();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pins.size() != 0);
  endtask

  task automatic send_enqueue(logic [31:0] cnt, logic [31:0] dly);
    send_request(make_request(OP_ENQUEUE, cnt, dly));
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) send_request(make_request(OP_TICK, $urandom(), $urandom()));
  endtask

  task automatic test_empty_ticks();
    send_request(make_request(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_TICK, 32'h0, 32'h0));
  endtask

  // zero and most negative counts both give zero toggles
  task automatic test_zero_toggle_commands();
    send_enqueue(32'd0, 32'hFFFF_FFFF);
    send_enqueue(32'h8000_0000, 32'd0);
    send_ticks(3);
  endtask

  task automatic test_zero_delay_and_pop();
    send_enqueue(32'd1, 32'd0);
    send_enqueue(32'hFFFF_FFFF, 32'd2);
    send_enqueue(32'd2, 32'd1);
    send_ticks(9);
  endtask

  task automatic test_random_traffic(int total);
    int enq_pct;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 57; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 57; end
        default: begin send_gap_pct = 6; stall_pct = 6; end
      endcase
      for (int i = 0; i < total / 4; i++) begin
        if (i % 24 == 0) begin
          case ($urandom_range(2))
            0: enq_pct = 15;
            1: enq_pct = 35;
            default: enq_pct = 70;
          endcase
        end
        if ($urandom_range(99) < enq_pct) begin
          if ($urandom_range(99) < 88)
            send_enqueue(32'($urandom_range(10)) - 32'd5, $urandom_range(3));
          else
            send_enqueue($urandom_range(1) ? 32'h8000_0000 : 32'd0, $urandom());
        end else begin
          send_ticks(1);
        end
      end
      drain_pins();
    end
    send_gap_pct = 0;
    stall_pct = 0;
  endtask

  // head that never finishes, then overflow the queue behind it
  task automatic test_stuck_head_and_full_queue();
    send_enqueue(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_ticks(2);
    send_enqueue(32'h8000_0001, 32'd0);
    for (int i = 0; i < QUEUE_DEPTH; i++) send_enqueue(32'd1, 32'd0);
    send_ticks(2);
  endtask

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pins.size() == 0) begin
        $error("result with no request pending");
        error_count++;
      end else begin
        oldest_pins = expected_pins.pop_front();
        check_field("step_level", 32'(oldest_pins.step_level), 32'(result.step_level));
        check_field("direction_level", 32'(oldest_pins.direction_level),
                    32'(result.direction_level));
        check_field("queue_count", 32'(oldest_pins.queue_count), 32'(result.queue_count));
        check_field("enqueue_rejected", 32'(oldest_pins.enqueue_rejected),
                    32'(result.enqueue_rejected));
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= NO_PROGRESS_LIMIT) begin
      $display("tb_stepper_command_queue_pulser_top failed");
      $finish;
    end else if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    request <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_ticks();
    test_zero_toggle_commands();
    test_zero_delay_and_pop();
    drain_pins();
    test_random_traffic(900);
    test_stuck_head_and_full_queue();
    drain_pins();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_pins.size() == 0) begin
      $display("tb_stepper_command_queue_pulser_top passed");
    end else begin
      $display("tb_stepper_command_queue_pulser_top failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/scqp_pkg.sv
rtl/scqp_front.sv
rtl/scqp_cmd_queue.sv
rtl/scqp_back.sv
rtl/stepper_command_queue_pulser_top.sv
rtl/scqp_checker.sv
bench/tb_stepper_command_queue_pulser_top.sv
